/* design/url_percent_decoder_core_assert.svh */
// Assertion macros shared by the URL percent-decoder checker.
// Needs a clk and rst signal in the scope where a macro is used.
`ifndef URL_PERCENT_DECODER_CORE_ASSERT_SVH
`define URL_PERCENT_DECODER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define URLPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("url_percent_decoder_core: assertion failed");

// Check that cons holds in the cycle after ante.
`define URLPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("url_percent_decoder_core: assertion failed");

`endif

/* design/urlpd_pkg.sv */
// Types, character constants and escape lookup for the URL percent-decoder.
// No dependencies; used by url_percent_decoder_core.
package urlpd_pkg;

  // Escape tracking state, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,  // outside an escape
    PH_PCT  = 3'b010,  // '%' seen
    PH_HI   = 3'b100   // first escape character seen
  } phase_t;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Upper-case hex digit: {is_digit, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Accepted escape values
  function automatic logic is_known_code(input logic [7:0] v);
    logic hit;
    case (v)
      8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2B,
      8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
      8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D,
      8'h7E:   hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* design/url_percent_decoder_core.sv */
// URL percent-decoder for a byte stream.
// Uses urlpd_pkg for the escape state type and code lookup.
//
// Usage:
//   Input request on s_axis: one raw byte of the encoded string in tdata,
//   tlast on the final byte of the string. Output request on m_axis: one
//   result per input byte. tdata carries the decoded byte (zero when none),
//   tuser[0] says a decoded byte is present, tuser[1] says an unknown or
//   truncated escape was discarded, tlast copies the input tlast.
//   '+' becomes a space; '%' plus two upper-case hex characters decodes only
//   for the fixed set of known codes; the '%' and first escape character
//   give results with both flags clear unless they carry tlast.
//   Throughput: one byte per cycle while m_axis_tready is high, set by the
//   single decode stage between the input register and the result register.
//   Stall: when m_axis_tready is low the result holds and the input register
//   still takes one more request; s_axis_tready drops once both are full.
//   Reset: rst clears both stages and returns to the outside-escape state,
//   so the next byte starts a new string.
module url_percent_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] out_valid, [1] escape_dropped
  output logic       m_axis_tlast
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_last;
  urlpd_pkg::phase_t phase;
  urlpd_pkg::phase_t phase_next;
  logic [7:0]        first_char;
  logic [7:0]        first_char_next;
  logic [7:0]        res_byte;
  logic              res_valid;
  logic              res_drop;
  logic              advance;
  logic [4:0]        hi_nib;
  logic [4:0]        lo_nib;
  logic [7:0]        esc_value;

  // Move the held request into the result register when it is free
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Escape value from the stored first character and the current byte
  assign hi_nib    = urlpd_pkg::hex_nibble(first_char);
  assign lo_nib    = urlpd_pkg::hex_nibble(in_byte);
  assign esc_value = {hi_nib[3:0], lo_nib[3:0]};

  // Decode one byte against the escape state
  always_comb begin
    res_byte        = 8'd0;
    res_valid       = 1'b0;
    res_drop        = 1'b0;
    phase_next      = urlpd_pkg::PH_IDLE;
    first_char_next = 8'd0;
    unique case (phase)
      urlpd_pkg::PH_PCT: begin
        if (in_last) begin
          res_drop = 1'b1;
        end else begin
          first_char_next = in_byte;
          phase_next      = urlpd_pkg::PH_HI;
        end
      end
      urlpd_pkg::PH_HI: begin
        if (hi_nib[4] && lo_nib[4] && urlpd_pkg::is_known_code(esc_value)) begin
          res_byte  = esc_value;
          res_valid = 1'b1;
        end else begin
          res_drop = 1'b1;
        end
      end
      default: begin
        if (in_byte == urlpd_pkg::CHAR_PCT) begin
          if (in_last) begin
            res_drop = 1'b1;
          end else begin
            phase_next = urlpd_pkg::PH_PCT;
          end
        end else if (in_byte == urlpd_pkg::CHAR_PLUS) begin
          res_byte  = urlpd_pkg::CHAR_SPACE;
          res_valid = 1'b1;
        end else begin
          res_byte  = in_byte;
          res_valid = 1'b1;
        end
      end
    endcase
  end

  // Escape state advances with each decoded request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= urlpd_pkg::PH_IDLE;
      first_char <= 8'd0;
    end else if (advance) begin
      phase      <= phase_next;
      first_char <= first_char_next;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= {res_drop, res_valid};
      m_axis_tlast <= in_last;
    end
  end

endmodule

/* design/urlpd_checker.sv */
// Port-level checks for url_percent_decoder_core, bound into each instance of it.
// Uses the macros of url_percent_decoder_core_assert.svh.
`include "url_percent_decoder_core_assert.svh"

module urlpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A waiting request holds its payload
  `URLPD_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
    s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))

  // A stalled result holds its payload
  `URLPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // A step never both emits a byte and drops an escape
  `URLPD_ASSERT_NOW(a_flags_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

  // No byte present means a zero data field
  `URLPD_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)

  // A silent step is inside an open escape, so it cannot end the string
  `URLPD_ASSERT_NOW(a_silent_not_last, m_axis_tvalid && m_axis_tuser == 2'b00, !m_axis_tlast)

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
